@@ src/fde_pkg.sv @@
package fde_pkg;

  localparam int NUM_W     = 6;
  localparam int DEN_W     = 7;
  localparam int DIGIT_W   = 4;
  localparam int POS_W     = 6;
  localparam int REM_W     = 6;
  localparam int REM_N     = 1 << REM_W;
  localparam int PROD_W    = 10;
  localparam int CNT_W     = 7;
  localparam int QUO_W     = 4;
  localparam int STEP_W    = 2;
  localparam int DEN_MAX   = 64;
  localparam int DIGIT_CAP = 64;
  localparam int RADIX     = 10;
  localparam int DATA_W    = 16;
  localparam int USER_W    = 2;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [DEN_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic [QUO_W-1:0] quo;
    logic [REM_W-1:0] rem;
  } div_res_t;

endpackage

@@ src/fde_div.sv @@
module fde_div (
  input  logic               clk,
  input  logic               rst,
  input  fde_pkg::div_req_t  req,
  output fde_pkg::div_res_t  res,
  output logic               done
);

  logic                         busy;
  logic [fde_pkg::STEP_W-1:0]   step;
  logic [fde_pkg::PROD_W-1:0]   part;
  logic [fde_pkg::QUO_W-1:0]    quo;
  logic [fde_pkg::DEN_W-1:0]    divisor;
  logic [fde_pkg::PROD_W:0]     shifted;
  logic                         fits;

  // Restoring division, one quotient bit per cycle, most significant bit first.
  assign shifted = {{(fde_pkg::PROD_W + 1 - fde_pkg::DEN_W){1'b0}}, divisor} << step;
  assign fits    = {1'b0, part} >= shifted;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy    <= 1'b1;
        step    <= fde_pkg::STEP_W'(fde_pkg::QUO_W - 1);
        part    <= req.dividend;
        divisor <= req.divisor;
      end else if (busy) begin
        if (fits) begin
          part <= part - shifted[fde_pkg::PROD_W-1:0];
        end
        quo[step] <= fits;
        step      <= step - 1'b1;
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res.quo = quo;
  assign res.rem = part[fde_pkg::REM_W-1:0];

endmodule

@@ src/fraction_decimal_expansion_top.sv @@
// Decimal expansion of a proper fraction by long division.
// Input channel s_*: one item carries a numerator and a denominator. The block
// then finds the digits after the decimal point, stopping when the remainder
// reaches zero or when a remainder shows up a second time.
// Output channel m_*: one item per digit, in order, with its position, a flag
// for digits inside the recurring cycle, and tlast on the final digit. A zero
// denominator, a denominator above 64 or a numerator not below the denominator
// gives a single item with the status flag set and tlast high.
// Sequencing: for each digit the sequencer does a remainder lookup, a run of the
// bit-serial divider and a retire step; then each digit is emitted: digit
// memory read, then the output register. A fraction has at most 64 digits.
// s_tready is high only while the block is idle; one fraction is in work at a
// time. A stalled receiver simply holds the current output item.
// Reset is synchronous and returns the block to idle with no output pending;
// the remainder table needs no clearing pass since its valid bits are cleared
// together when each fraction is accepted.
module fraction_decimal_expansion_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // [5:0] numerator, [12:6] denominator, [15:13] zero
  input  logic [fde_pkg::DATA_W-1:0]  s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // [3:0] digit, [9:4] position, [15:10] zero
  output logic [fde_pkg::DATA_W-1:0]  m_tdata,
  output logic                        m_tlast,
  // [0] repeating, [1] status
  output logic [fde_pkg::USER_W-1:0]  m_tuser
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOK = 3'd1;
  localparam logic [2:0] S_RING = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_SEND = 3'd5;

  logic [2:0]                    state;
  logic [fde_pkg::NUM_W-1:0]     in_num;
  logic [fde_pkg::DEN_W-1:0]     in_den;
  logic                          in_bad;
  logic [fde_pkg::DEN_W-1:0]     den;
  logic [fde_pkg::REM_W-1:0]     rem;
  logic [fde_pkg::CNT_W-1:0]     count;
  logic [fde_pkg::POS_W-1:0]     cyc_start;
  logic                          ring;
  logic                          err;
  logic [fde_pkg::POS_W-1:0]     idx;
  logic [fde_pkg::REM_N-1:0]     seen_vld;
  logic [fde_pkg::POS_W-1:0]     seen_mem [fde_pkg::REM_N];
  logic [fde_pkg::POS_W-1:0]     seen_rd;
  logic [fde_pkg::DIGIT_W-1:0]   digit_mem [fde_pkg::DIGIT_CAP];
  logic [fde_pkg::DIGIT_W-1:0]   digit_rd;
  logic                          out_rep;
  logic                          out_last;
  logic                          s_fire;
  logic                          m_fire;
  logic                          look_go;
  fde_pkg::div_req_t             div_req;
  fde_pkg::div_res_t             div_res;
  logic                          div_done;

  assign in_num = s_tdata[fde_pkg::NUM_W-1:0];
  assign in_den = s_tdata[fde_pkg::NUM_W +: fde_pkg::DEN_W];
  assign in_bad = (in_den == '0) || ({1'b0, in_num} >= in_den)
               || (in_den > fde_pkg::DEN_W'(fde_pkg::DEN_MAX));

  assign s_tready = (state == S_IDLE);
  assign s_fire   = s_tvalid && s_tready;
  assign m_tvalid = (state == S_SEND);
  assign m_fire   = m_tvalid && m_tready;

  // A new division starts when the digit cap is not reached and the remainder is new.
  assign look_go = (state == S_LOOK) && (count != fde_pkg::CNT_W'(fde_pkg::DIGIT_CAP))
                && !seen_vld[rem];

  assign div_req.start    = look_go;
  assign div_req.dividend = fde_pkg::PROD_W'(rem) * fde_pkg::PROD_W'(fde_pkg::RADIX);
  assign div_req.divisor  = den;

  fde_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .res  (div_res),
    .done (div_done)
  );

  always_ff @(posedge clk) begin
    seen_rd <= seen_mem[rem];
    if (look_go) begin
      seen_mem[rem] <= count[fde_pkg::POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    digit_rd <= digit_mem[idx];
    if (state == S_DIV && div_done) begin
      digit_mem[count[fde_pkg::POS_W-1:0]] <= div_res.quo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      seen_vld <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_fire) begin
            den       <= in_den;
            rem       <= in_num;
            count     <= '0;
            idx       <= '0;
            ring      <= 1'b0;
            cyc_start <= '0;
            seen_vld  <= '0;
            err       <= in_bad;
            if (in_bad) begin
              out_rep  <= 1'b0;
              out_last <= 1'b1;
              state    <= S_SEND;
            end else begin
              state <= S_LOOK;
            end
          end
        end
        S_LOOK: begin
          if (count == fde_pkg::CNT_W'(fde_pkg::DIGIT_CAP)) begin
            state <= S_RD;
          end else if (seen_vld[rem]) begin
            state <= S_RING;
          end else begin
            seen_vld[rem] <= 1'b1;
            state         <= S_DIV;
          end
        end
        S_RING: begin
          ring      <= 1'b1;
          cyc_start <= seen_rd;
          state     <= S_RD;
        end
        S_DIV: begin
          if (div_done) begin
            rem   <= div_res.rem;
            count <= count + 1'b1;
            state <= (div_res.rem == '0) ? S_RD : S_LOOK;
          end
        end
        S_RD: begin
          out_rep  <= ring && (idx >= cyc_start);
          out_last <= (fde_pkg::CNT_W'(idx) + 1'b1) == count;
          state    <= S_SEND;
        end
        S_SEND: begin
          if (m_fire) begin
            if (out_last) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {{(fde_pkg::DATA_W - fde_pkg::DIGIT_W - fde_pkg::POS_W){1'b0}},
                    idx, err ? {fde_pkg::DIGIT_W{1'b0}} : digit_rd};
  assign m_tlast = out_last;
  assign m_tuser = {err, out_rep};

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input accepted while a result is pending");

  a_err_single: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |-> (m_tlast && !m_tuser[0] && m_tdata == '0))
    else $error("error result not a single cleared last item");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[fde_pkg::DIGIT_W-1:0] <= fde_pkg::DIGIT_W'(9)))
    else $error("digit out of decimal range");

  a_back_to_idle: assert property (@(posedge clk) disable iff (rst)
    (m_fire && m_tlast) |=> s_tready)
    else $error("block not idle after final item");

endmodule
